// ===== design/tcgw_pkg.sv =====
// ============================================================================
// tcgw_pkg: shared types and constants for the text console glyph writer
// Word layouts of the input and result queues, configuration and command types.
// ============================================================================
package tcgw_pkg;

    localparam int GLYPH_WIDTH        = 8;
    localparam int GLYPH_COUNT_DEF    = 256;
    localparam int GLYPH_ROWS_DEF     = 16;
    localparam int CMDQ_DEPTH         = 4;
    localparam int OUTQ_DEPTH         = 4;

    localparam int ADDR_W             = 48;
    localparam int PITCH_W            = 14;
    localparam int COLOR_W            = 32;
    localparam int CFG_DATA_W         = 48;

    localparam logic [0:0] OP_LOAD    = 1'b0;
    localparam logic [0:0] OP_PRINT   = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;

    localparam logic [1:0] CFG_FB_BASE         = 2'd0;
    localparam logic [1:0] CFG_PIXELS_PER_LINE = 2'd1;
    localparam logic [1:0] CFG_SCREEN_WIDTH    = 2'd2;
    localparam logic [1:0] CFG_TEXT_COLOR      = 2'd3;

    typedef struct packed {
        logic [0:0]             opcode;
        logic [7:0]             char_code;
        logic [3:0]             glyph_row;
        logic [GLYPH_WIDTH-1:0] font_byte;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]      write_address;
        logic [GLYPH_WIDTH-1:0] write_mask;
        logic [COLOR_W-1:0]     write_color;
        logic                   last_row;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  fb_base;
        logic [PITCH_W-1:0] pixels_per_line;
        logic [PITCH_W-1:0] screen_width;
        logic [COLOR_W-1:0] text_color;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fb_base:         48'd0,
        pixels_per_line: 14'd1024,
        screen_width:    14'd1024,
        text_color:      32'hFFFF_FFFF
    };

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_NEWLINE,
        KIND_TAB,
        KIND_PRINT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [7:0]             glyph;
        logic [3:0]             row;
        logic [GLYPH_WIDTH-1:0] font_byte;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_push;
        logic out_full;
        logic out_last;
    } back_stat_t;

endpackage

// ===== design/tcgw_ram.sv =====
// ============================================================================
// tcgw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module tcgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tcgw_fifo.sv =====
// ============================================================================
// tcgw_fifo: small register queue
// Flip-flop storage with a fill level; the head word is shown while not empty.
// ============================================================================
module tcgw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == LVL_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign level = count_reg;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/tcgw_front.sv =====
// ============================================================================
// tcgw_front: input classifier and command queue
// Sorts incoming words into glyph loads, cursor controls and prints; drops code zero and out-of-range load rows.
// ============================================================================
module tcgw_front
    import tcgw_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  cmd_valid,
    output cmd_t  cmd,
    input  logic  cmd_pop
);

    cmd_t       cmd_in;
    logic       keep;
    logic       cmdq_empty;
    logic [7:0] glyph;

    always_comb
    begin
        // Codes at or above the glyph count have the glyph count subtracted once.
        glyph = item.char_code;
        if (32'(item.char_code) >= GLYPH_COUNT)
        begin
            glyph = item.char_code - 8'(GLYPH_COUNT);
        end

        keep             = 1'b1;
        cmd_in.kind      = KIND_PRINT;
        cmd_in.glyph     = glyph;
        cmd_in.row       = item.glyph_row;
        cmd_in.font_byte = item.font_byte;

        unique case (item.opcode)
            OP_LOAD:
            begin
                cmd_in.kind = KIND_LOAD;
                keep        = (32'(item.glyph_row) < GLYPH_ROWS);
            end
            OP_PRINT:
            begin
                unique case (item.char_code)
                    CHAR_NUL: keep        = 1'b0;
                    CHAR_TAB: cmd_in.kind = KIND_TAB;
                    CHAR_NL:  cmd_in.kind = KIND_NEWLINE;
                    default:  cmd_in.kind = KIND_PRINT;
                endcase
            end
            default: keep = 1'b0;
        endcase
    end

    tcgw_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .full    (full),
        .empty   (cmdq_empty),
        .level   ()
    );

    assign cmd_valid = !cmdq_empty;

endmodule

// ===== design/tcgw_back.sv =====
// ============================================================================
// tcgw_back: glyph store, cursor and row-write sequencer
// Executes commands in order and queues one masked row write per glyph row.
// ============================================================================
module tcgw_back
    import tcgw_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  cfg_t       cfg,
    output logic       empty,
    input  logic       pop,
    output result_t    result,
    output back_stat_t stat
);

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(GLYPH_ROWS);
    localparam int LVL_W       = $clog2(OUTQ_DEPTH + 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

    localparam logic [15:0] CUR_X0   = 16'd8;
    localparam logic [15:0] CUR_Y0   = 16'd16;
    localparam logic [15:0] CHAR_ADV = 16'd8;
    localparam logic [15:0] TAB_ADV  = 16'd32;
    localparam logic [15:0] LINE_ADV = 16'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_ROWS
    } state_t;

    function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // Returns {x, y} after one control code or printed character.
    function automatic logic [31:0] cursor_step(cmd_kind_t kind, logic [15:0] x,
                                                logic [15:0] y, logic [PITCH_W-1:0] sw);
        logic [15:0] nx;
        logic [15:0] ny;
        nx = x;
        ny = y;
        case (kind) inside
            KIND_NEWLINE:
            begin
                nx = CUR_X0;
                ny = sat_add(y, LINE_ADV);
            end
            KIND_TAB: nx = sat_add(x, TAB_ADV);
            default:  nx = sat_add(x, CHAR_ADV);
        endcase
        if (nx > 16'(sw))
        begin
            nx = CUR_X0;
            ny = sat_add(ny, LINE_ADV);
        end
        return {nx, ny};
    endfunction

    state_t              state_reg, state_next;
    logic [15:0]         cur_x_reg, cur_x_next;
    logic [15:0]         cur_y_reg, cur_y_next;
    logic [29:0]         prod_reg, prod_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SA_W-1:0]     gbase_reg, gbase_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic                rd_last_reg, rd_last_next;

    logic                ram_we;
    logic [SA_W-1:0]     ram_waddr;
    logic [SA_W-1:0]     ram_raddr;
    logic [7:0]          ram_rdata;
    logic [30:0]         pix;
    logic [31:0]         step;
    logic [LVL_W-1:0]    out_level;
    logic                out_full;
    result_t             out_word;

    assign pix       = {1'b0, prod_reg} + 31'(cur_x_reg);
    assign ram_waddr = SA_W'(32'(cmd.glyph) * GLYPH_ROWS + 32'(cmd.row));
    assign ram_raddr = gbase_reg + SA_W'(row_reg);

    always_comb
    begin
        state_next    = state_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        prod_next     = prod_reg;
        addr_next     = addr_reg;
        gbase_next    = gbase_reg;
        row_next      = row_reg;
        rd_valid_next = 1'b0;
        rd_addr_next  = addr_reg;
        rd_last_next  = (row_reg == LAST_ROW);
        cmd_pop       = 1'b0;
        ram_we        = 1'b0;
        step          = cursor_step(KIND_PRINT, cur_x_reg, cur_y_reg, cfg.screen_width);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind) inside
                        KIND_LOAD: ram_we = 1'b1;
                        KIND_NEWLINE, KIND_TAB:
                        begin
                            step = cursor_step(cmd.kind, cur_x_reg, cur_y_reg,
                                               cfg.screen_width);
                            cur_x_next = step[31:16];
                            cur_y_next = step[15:0];
                        end
                        default:
                        begin
                            gbase_next = SA_W'(32'(cmd.glyph) * GLYPH_ROWS);
                            prod_next  = 30'(cur_y_reg) * 30'(cfg.pixels_per_line);
                            state_next = ST_BASE;
                        end
                    endcase
                end
            end
            ST_BASE:
            begin
                addr_next  = cfg.fb_base + ADDR_W'({pix, 2'b00});
                row_next   = '0;
                state_next = ST_ROWS;
            end
            ST_ROWS:
            begin
                // Keep one slot free for the row whose glyph byte is in flight.
                if (out_level <= LVL_W'(OUTQ_DEPTH - 2))
                begin
                    rd_valid_next = 1'b1;
                    addr_next     = addr_reg + ADDR_W'({cfg.pixels_per_line, 2'b00});
                    row_next      = row_reg + 1'b1;
                    if (row_reg == LAST_ROW)
                    begin
                        cur_x_next = step[31:16];
                        cur_y_next = step[15:0];
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_x_reg    <= CUR_X0;
            cur_y_reg    <= CUR_Y0;
            prod_reg     <= '0;
            addr_reg     <= '0;
            gbase_reg    <= '0;
            row_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            prod_reg     <= prod_next;
            addr_reg     <= addr_next;
            gbase_reg    <= gbase_next;
            row_reg      <= row_next;
            rd_valid_reg <= rd_valid_next;
            rd_addr_reg  <= rd_addr_next;
            rd_last_reg  <= rd_last_next;
        end
    end

    tcgw_ram #(
        .WIDTH (GLYPH_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.font_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_word.write_address = rd_addr_reg;
    assign out_word.write_mask    = ram_rdata;
    assign out_word.write_color   = cfg.text_color;
    assign out_word.last_row      = rd_last_reg;

    tcgw_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rd_valid_reg),
        .wr_data (out_word),
        .rd_en   (pop),
        .rd_data (result),
        .full    (out_full),
        .empty   (empty),
        .level   (out_level)
    );

    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.out_push = rd_valid_reg;
    assign stat.out_full = out_full;
    assign stat.out_last = rd_last_reg;

endmodule

// ===== design/text_console_glyph_writer.sv =====
// ============================================================================
// text_console_glyph_writer: character-driven glyph renderer
// Draws 8-pixel-wide glyphs from a loadable glyph store into a framebuffer.
// ============================================================================
// Input queue: drive item and push while full is low. Load words fill one
// glyph row; print words move the cursor or draw a character.
// Result queue: while empty is low, result holds the oldest row write; pop
// takes it. A printed character gives GLYPH_ROWS row writes, the last one
// flagged by last_row. Loads, tab, newline and code zero give no word.
// Configuration: write cfg_data to register cfg_index with cfg_valid; the
// port is always ready. Write only while the block is idle.
// Timing: a character's word passes the command queue, the base and row
// states and the glyph read register before its first row write; then one
// row per cycle while the result queue has room, each read through the single
// read port of the glyph store. Loads and cursor codes finish in the idle state.
// Reset puts the cursor at (8,16), restores register defaults and empties
// both queues; the glyph store is not cleared. When the receiver stalls,
// rows collect in a four-word queue, then the sequencer waits, and the
// four-word command queue lets input keep flowing until it fills.
// ============================================================================
module text_console_glyph_writer
    import tcgw_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  item_t                 item,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    back_stat_t bstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FB_BASE:         cfg_reg.fb_base         <= cfg_data[ADDR_W-1:0];
                CFG_PIXELS_PER_LINE: cfg_reg.pixels_per_line <= cfg_data[PITCH_W-1:0];
                CFG_SCREEN_WIDTH:    cfg_reg.screen_width    <= cfg_data[PITCH_W-1:0];
                CFG_TEXT_COLOR:      cfg_reg.text_color      <= cfg_data[COLOR_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    tcgw_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tcgw_back #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg_reg),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .stat      (bstat)
    );

    // The back end only takes a command the front end is presenting.
    a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty command queue");

    // The row credit check must keep the result queue from overflowing.
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.out_push |-> !bstat.out_full)
        else $error("row write pushed into a full result queue");

    // The final row lands after the sequencer has already returned to idle.
    a_last_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (bstat.out_push && bstat.out_last) |-> !bstat.busy)
        else $error("last row of a character queued while still sequencing");

endmodule
